// File: design/fvpm_pkg.sv
// shared types, constants and command encodings for the four-voice pcm mixer
// used by fvpm_ctrl, fvpm_datapath and four_voice_pcm_mixer_top; no dependencies
package fvpm_pkg;

	localparam int NUM_VOICES    = 4;
	localparam int MAX_VOICES    = 4;
	localparam int POSITION_BITS = 23;
	localparam int FADE_LENGTH   = 882;

	localparam int VIDX_BITS      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SEL_BITS       = 2;
	localparam int LANES          = 2;
	localparam int SAMPLE_BITS    = 16;
	localparam int CLIP_BITS      = 23;
	localparam int FADE_BITS      = 10;
	localparam int CFG_BITS       = 7;
	localparam int CFG_INDEX_BITS = 2;
	localparam int ACC_BITS       = 18;
	localparam int MUL_BITS       = 28;
	localparam int PROD_BITS      = 2 * MUL_BITS;
	localparam int LEN_CMP_BITS   = (CLIP_BITS > POSITION_BITS) ? CLIP_BITS : POSITION_BITS;

	// truncating divide by the fade length through a reciprocal multiply
	localparam int    FADE_SHIFT = 15 + 2 * $clog2(FADE_LENGTH);
	localparam longint FADE_RECIP =
		((longint'(1) << FADE_SHIFT) + FADE_LENGTH - 1) / FADE_LENGTH;

	// gain = vol * fs * 256 / 10000, same reciprocal trick
	localparam int     PCT_MAX      = 100;
	localparam int     GAIN_SCALE   = 256;
	localparam int     GAIN_DIV     = 10000;
	localparam int     GAIN_BITS    = 9;
	localparam int     GPROD_BITS   = 2 * CFG_BITS;
	localparam int     GX_BITS      = GPROD_BITS + $clog2(GAIN_SCALE);
	localparam int     GAIN_SHIFT   = 36;
	localparam longint GAIN_RECIP   =
		((longint'(1) << GAIN_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
	localparam int     GMUL_BITS    = 64;

	localparam int OUT_SHIFT = 8;
	localparam int SAT_MAX   = 32767;
	localparam int SAT_MIN   = -32768;

	localparam int VOLUME_RESET     = 50;
	localparam int FULL_SCALE_RESET = 100;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLUME     = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_SCALE = CFG_INDEX_BITS'(1);

	typedef enum logic [1:0] {
		REQ_PLAY  = 2'd0,
		REQ_STOP  = 2'd1,
		REQ_FRAME = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FADE,
		ST_RECIP,
		ST_ACCUM,
		ST_GAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_CONTROL,
		OP_MUL_FADE,
		OP_MUL_RECIP,
		OP_ACCUM,
		OP_MUL_GAIN,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [VIDX_BITS-1:0] voice;
	} dp_cmd_t;

	typedef struct packed {
		logic is_frame;
	} dp_status_t;

endpackage

// File: design/fvpm_ctrl.sv
// sequencer for the mixer: handshakes on both channels and walks the voices
// depends on fvpm_pkg; drives fvpm_datapath through dp_cmd_t
module fvpm_ctrl
	import fvpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t               state_q, state_nxt;
	logic [VIDX_BITS-1:0] voice_q;
	logic                 out_valid_q;
	logic                 last_voice;
	logic                 out_free;

	assign last_voice = (voice_q == VIDX_BITS'(NUM_VOICES - 1));
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
			ST_DECODE: state_nxt = status.is_frame ? ST_FADE : ST_FINISH;
			ST_FADE:   state_nxt = ST_RECIP;
			ST_RECIP:  state_nxt = ST_ACCUM;
			ST_ACCUM:  state_nxt = last_voice ? ST_GAIN : ST_FADE;
			ST_GAIN:   state_nxt = ST_FINISH;
			ST_FINISH: if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.voice = voice_q;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_DECODE: if (!status.is_frame) cmd.op = OP_CONTROL;
			ST_FADE:   cmd.op = OP_MUL_FADE;
			ST_RECIP:  cmd.op = OP_MUL_RECIP;
			ST_ACCUM:  cmd.op = OP_ACCUM;
			ST_GAIN:   cmd.op = OP_MUL_GAIN;
			ST_FINISH: if (out_free) cmd.op = OP_RESULT;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			voice_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DECODE) begin
				voice_q <= '0;
			end else if (state_q == ST_ACCUM && !last_voice) begin
				voice_q <= voice_q + 1'b1;
			end
			if (cmd.op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/fvpm_datapath.sv
// voice state, config registers, two-lane multiply/accumulate and result registers
// depends on fvpm_pkg; commanded by fvpm_ctrl
module fvpm_datapath
	import fvpm_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_status_t                    status,
	input  logic [1:0]                    req_type,
	input  logic [CLIP_BITS-1:0]          clip_frames,
	input  logic                          loop_flag,
	input  logic [SEL_BITS-1:0]           voice_select,
	input  logic signed [SAMPLE_BITS-1:0] samples_l [MAX_VOICES],
	input  logic signed [SAMPLE_BITS-1:0] samples_r [MAX_VOICES],
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data,
	output logic signed [SAMPLE_BITS-1:0] mix_l,
	output logic signed [SAMPLE_BITS-1:0] mix_r,
	output logic [1:0]                    vidx,
	output logic                          rej,
	output logic [MAX_VOICES-1:0]         act_mask,
	output logic [MAX_VOICES-1:0]         fade_mask,
	output logic [CLIP_BITS-1:0]          npos [MAX_VOICES]
);

	// request capture
	req_t                          req_q;
	logic [CLIP_BITS-1:0]          frames_q;
	logic                          loopf_q;
	logic [SEL_BITS-1:0]           sel_q;
	logic signed [SAMPLE_BITS-1:0] smp_q [LANES][MAX_VOICES];
	logic [1:0]                    vidx_q;
	logic                          rej_q;

	// voice state
	logic [NUM_VOICES-1:0]    active_q;
	logic [NUM_VOICES-1:0]    looping_q;
	logic [POSITION_BITS-1:0] pos_q  [NUM_VOICES];
	logic [POSITION_BITS-1:0] len_q  [NUM_VOICES];
	logic [FADE_BITS-1:0]     fade_q [NUM_VOICES];

	// config and gain
	logic [CFG_BITS-1:0]   vol_q, fs_q, vol_cl, fs_cl;
	logic [GPROD_BITS-1:0] gprod_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [GX_BITS-1:0]    gx;
	logic [GMUL_BITS-1:0]  gmul;

	// lanes
	logic signed [MUL_BITS-1:0]  mul_a   [LANES];
	logic signed [MUL_BITS-1:0]  mul_b   [LANES];
	logic signed [PROD_BITS-1:0] pabs    [LANES];
	logic signed [PROD_BITS-1:0] prod_q  [LANES];
	logic                        neg_q   [LANES];
	logic signed [ACC_BITS-1:0]  acc_q   [LANES];
	logic [ACC_BITS-1:0]         q_ext   [LANES];
	logic signed [ACC_BITS-1:0]  scaled  [LANES];
	logic signed [ACC_BITS-1:0]  contrib [LANES];
	logic signed [PROD_BITS-1:0] shifted [LANES];
	logic signed [SAMPLE_BITS-1:0] sat  [LANES];

	// per-request helpers
	logic [VIDX_BITS-1:0]     vk, pick, sel_v;
	logic                     found;
	logic                     fading;
	logic [FADE_BITS-1:0]     fade_dec;
	logic [POSITION_BITS-1:0] pos_inc;
	logic                     at_end;
	logic [LEN_CMP_BITS-1:0]  frames_w, posmax_w;
	logic [POSITION_BITS-1:0] len_claim;
	logic                     stop_ok;

	assign vk = cmd.voice;
	assign status.is_frame = (req_q == REQ_FRAME);

	// lowest idle voice, else lowest non-looping one, else voice 0
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int k = 0; k < NUM_VOICES; k++) begin
			if (!found && !active_q[k]) begin
				pick  = VIDX_BITS'(k);
				found = 1'b1;
			end
		end
		for (int k = 0; k < NUM_VOICES; k++) begin
			if (!found && !looping_q[k]) begin
				pick  = VIDX_BITS'(k);
				found = 1'b1;
			end
		end
	end

	assign frames_w  = LEN_CMP_BITS'(frames_q);
	assign posmax_w  = LEN_CMP_BITS'({POSITION_BITS{1'b1}});
	assign len_claim = (frames_w > posmax_w) ? POSITION_BITS'(posmax_w)
		: POSITION_BITS'(frames_w);

	assign sel_v   = VIDX_BITS'(sel_q);
	assign stop_ok = (32'(sel_q) < NUM_VOICES) && active_q[sel_v] && (fade_q[sel_v] == '0);

	assign fading   = (fade_q[vk] != '0);
	assign fade_dec = fade_q[vk] - 1'b1;
	assign pos_inc  = pos_q[vk] + 1'b1;
	assign at_end   = (pos_inc >= len_q[vk]);

	// gain pipeline: clamped volume times full scale is registered in gprod_q, then scaled into gain_q
	assign vol_cl = (vol_q > CFG_BITS'(PCT_MAX)) ? CFG_BITS'(PCT_MAX) : vol_q;
	assign fs_cl  = (fs_q > CFG_BITS'(PCT_MAX)) ? CFG_BITS'(PCT_MAX) : fs_q;
	assign gx     = GX_BITS'(gprod_q) << $clog2(GAIN_SCALE);
	assign gmul   = GMUL_BITS'(gx) * GMUL_BITS'(GAIN_RECIP);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pabs[l]    = (prod_q[l] < 0) ? -prod_q[l] : prod_q[l];
			q_ext[l]   = ACC_BITS'(prod_q[l][FADE_SHIFT +: SAMPLE_BITS]);
			scaled[l]  = neg_q[l] ? -signed'(q_ext[l]) : signed'(q_ext[l]);
			contrib[l] = fading ? scaled[l] : ACC_BITS'(smp_q[l][vk]);
			shifted[l] = prod_q[l] >>> OUT_SHIFT;
			if (shifted[l] > PROD_BITS'(SAT_MAX)) begin
				sat[l] = SAMPLE_BITS'(SAT_MAX);
			end else if (shifted[l] < PROD_BITS'(SAT_MIN)) begin
				sat[l] = SAMPLE_BITS'(SAT_MIN);
			end else begin
				sat[l] = SAMPLE_BITS'(shifted[l]);
			end
			case (cmd.op)
				OP_MUL_FADE: begin
					mul_a[l] = MUL_BITS'(smp_q[l][vk]);
					mul_b[l] = signed'(MUL_BITS'(fade_q[vk]));
				end
				OP_MUL_RECIP: begin
					mul_a[l] = MUL_BITS'(pabs[l]);
					mul_b[l] = signed'(MUL_BITS'(FADE_RECIP));
				end
				OP_MUL_GAIN: begin
					mul_a[l] = MUL_BITS'(acc_q[l]);
					mul_b[l] = signed'(MUL_BITS'(gain_q));
				end
				default: begin
					mul_a[l] = '0;
					mul_b[l] = '0;
				end
			endcase
		end
	end

	// config registers and gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q   <= CFG_BITS'(VOLUME_RESET);
			fs_q    <= CFG_BITS'(FULL_SCALE_RESET);
			gprod_q <= '0;
			gain_q  <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_VOLUME:     vol_q <= cfg_data;
					CFG_FULL_SCALE: fs_q  <= cfg_data;
					default:        ;
				endcase
			end
			gprod_q <= GPROD_BITS'(vol_cl * fs_cl);
			gain_q  <= GAIN_BITS'(gmul >> GAIN_SHIFT);
		end
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			looping_q <= '0;
			for (int k = 0; k < NUM_VOICES; k++) begin
				pos_q[k]  <= '0;
				len_q[k]  <= '0;
				fade_q[k] <= '0;
			end
		end else begin
			if (cmd.op == OP_CONTROL) begin
				case (req_q)
					REQ_PLAY: begin
						if (frames_q != '0) begin
							active_q[pick]  <= 1'b1;
							looping_q[pick] <= loopf_q;
							pos_q[pick]     <= '0;
							len_q[pick]     <= len_claim;
							fade_q[pick]    <= '0;
						end
					end
					REQ_STOP: begin
						if (stop_ok) fade_q[sel_v] <= FADE_BITS'(FADE_LENGTH);
					end
					default: ;
				endcase
			end
			if (cmd.op == OP_ACCUM && active_q[vk]) begin
				if (fading) fade_q[vk] <= fade_dec;
				// a voice ends when its fade runs out, even if it loops
				active_q[vk] <= !(fading && fade_dec == '0) && !(at_end && !looping_q[vk]);
				pos_q[vk]    <= (at_end && looping_q[vk]) ? '0 : pos_inc;
			end
		end
	end

	// request capture, lane arithmetic and result registers
	// the result registers only change on OP_RESULT so a stalled result holds
	always_ff @(posedge clk) begin
		case (cmd.op) inside
			OP_LOAD: begin
				req_q    <= req_t'(req_type);
				frames_q <= clip_frames;
				loopf_q  <= loop_flag;
				sel_q    <= voice_select;
				vidx_q   <= '0;
				rej_q    <= 1'b0;
				for (int k = 0; k < MAX_VOICES; k++) begin
					smp_q[0][k] <= samples_l[k];
					smp_q[1][k] <= samples_r[k];
				end
				for (int l = 0; l < LANES; l++) acc_q[l] <= '0;
			end
			OP_CONTROL: begin
				if (req_q == REQ_PLAY) begin
					if (frames_q == '0) begin
						rej_q <= 1'b1;
					end else begin
						vidx_q <= 2'(pick);
					end
				end
			end
			OP_MUL_FADE: begin
				for (int l = 0; l < LANES; l++) begin
					prod_q[l] <= mul_a[l] * mul_b[l];
					neg_q[l]  <= smp_q[l][vk][SAMPLE_BITS-1];
				end
			end
			OP_MUL_RECIP, OP_MUL_GAIN: begin
				for (int l = 0; l < LANES; l++) prod_q[l] <= mul_a[l] * mul_b[l];
			end
			OP_ACCUM: begin
				if (active_q[vk]) begin
					for (int l = 0; l < LANES; l++) acc_q[l] <= acc_q[l] + contrib[l];
				end
			end
			OP_RESULT: begin
				mix_l <= status.is_frame ? sat[0] : '0;
				mix_r <= status.is_frame ? sat[1] : '0;
				vidx  <= vidx_q;
				rej   <= rej_q;
				for (int k = 0; k < MAX_VOICES; k++) begin
					if (k < NUM_VOICES && active_q[VIDX_BITS'(k)]) begin
						act_mask[k]  <= 1'b1;
						fade_mask[k] <= (fade_q[VIDX_BITS'(k)] != '0);
						npos[k]      <= CLIP_BITS'(pos_q[VIDX_BITS'(k)]);
					end else begin
						act_mask[k]  <= 1'b0;
						fade_mask[k] <= 1'b0;
						npos[k]      <= '0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// File: design/four_voice_pcm_mixer_top.sv
// Four-voice stereo pcm mixer with linear fade-out.
// Request channel (in_valid/in_ready): req_type picks play, stop, mix frame or
// no-op; play uses clip_frames and loop_flag, stop uses voice_select, a frame
// request brings one signed sample pair per voice at the positions last reported.
// Result channel (out_valid/out_ready): one result per request with the mixed
// frame (zero for other requests), the claimed voice, the reject flag, the
// active and fading masks and each voice's next read position.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 volume, 1 full
// scale percent; write only while no request is in flight.
// Sequence: for a frame, each voice passes through a fade multiply, a reciprocal
// multiply and an accumulate on each lane's shared multiplier, then come gain and
// output; play, stop and no-op requests go through decode and output only. A new
// request is taken only after the result of the previous one is registered.
// A stalled receiver holds the result register; the next request may be taken
// and worked on meanwhile, finishing once the previous result is taken.
// Reset clears all voices and sets volume 50, full scale 100.
// depends on fvpm_pkg, fvpm_ctrl and fvpm_datapath
module four_voice_pcm_mixer_top
	import fvpm_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [CLIP_BITS-1:0]          clip_frames,
	input  logic                          loop_flag,
	input  logic [SEL_BITS-1:0]           voice_select,
	input  logic signed [SAMPLE_BITS-1:0] sample_left_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_right_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_left_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_right_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_left_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_right_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_left_3,
	input  logic signed [SAMPLE_BITS-1:0] sample_right_3,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] mix_left,
	output logic signed [SAMPLE_BITS-1:0] mix_right,
	output logic [1:0]                    voice_index,
	output logic                          rejected,
	output logic [MAX_VOICES-1:0]         active_mask,
	output logic [MAX_VOICES-1:0]         fading_mask,
	output logic [CLIP_BITS-1:0]          next_pos_0,
	output logic [CLIP_BITS-1:0]          next_pos_1,
	output logic [CLIP_BITS-1:0]          next_pos_2,
	output logic [CLIP_BITS-1:0]          next_pos_3,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data
);

	dp_cmd_t                       cmd;
	dp_status_t                    status;
	logic signed [SAMPLE_BITS-1:0] smp_l [MAX_VOICES];
	logic signed [SAMPLE_BITS-1:0] smp_r [MAX_VOICES];
	logic [CLIP_BITS-1:0]          npos  [MAX_VOICES];

	assign smp_l[0] = sample_left_0;
	assign smp_l[1] = sample_left_1;
	assign smp_l[2] = sample_left_2;
	assign smp_l[3] = sample_left_3;
	assign smp_r[0] = sample_right_0;
	assign smp_r[1] = sample_right_1;
	assign smp_r[2] = sample_right_2;
	assign smp_r[3] = sample_right_3;

	assign next_pos_0 = npos[0];
	assign next_pos_1 = npos[1];
	assign next_pos_2 = npos[2];
	assign next_pos_3 = npos[3];

	assign cfg_ready = 1'b1;

	fvpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fvpm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.clip_frames  (clip_frames),
		.loop_flag    (loop_flag),
		.voice_select (voice_select),
		.samples_l    (smp_l),
		.samples_r    (smp_r),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mix_l        (mix_left),
		.mix_r        (mix_right),
		.vidx         (voice_index),
		.rej          (rejected),
		.act_mask     (active_mask),
		.fade_mask    (fading_mask),
		.npos         (npos)
	);

endmodule
